// ===== src/dfs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfs_pkg: shared types and constants
// Operand classes, unpacked operand record and binary64 field constants.
// ---------------------------------------------------------------------------
package dfs_pkg;

  localparam int ExpW = 13;

  localparam logic [63:0] FracMask = 64'h000f_ffff_ffff_ffff;
  localparam logic [10:0] ExpAll   = 11'h7ff;
  localparam logic [63:0] CanonNan = 64'h7ff8_0000_0000_0000;
  localparam logic [51:0] QuietBit = 52'h8_0000_0000_0000;

  typedef enum logic [1:0] {
    K_NAN,
    K_ZERO,
    K_NUM,
    K_INF
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic                   sgn;
    logic signed [ExpW-1:0] ex;
    logic [63:0]            sig;
  } unpacked_t;

endpackage

// ===== src/dfs_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfs_if: valid/ready channel
// Carries a request with a payload of parameterized width.
// ---------------------------------------------------------------------------
interface dfs_if #(
  parameter int W = 64
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/dfs_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfs_in_if: operand channel
// Carries the minuend and subtrahend of one request.
// ---------------------------------------------------------------------------
interface dfs_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] minuend;
  logic [63:0] subtrahend;

  modport source (output valid, output minuend, output subtrahend, input ready);
  modport sink (input valid, input minuend, input subtrahend, output ready);
endinterface

// ===== src/dfs_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfs_datapath: combinational binary64 subtract
// Unpack, align, add/subtract, normalize, round and pack.
// ---------------------------------------------------------------------------
module dfs_datapath
  import dfs_pkg::*;
(
  input  logic [63:0] minuend,
  input  logic [63:0] subtrahend,
  output logic [63:0] difference
);

  function automatic unpacked_t split(input logic [63:0] bits);
    unpacked_t u;
    logic [63:0] f;
    logic [10:0] e;
    logic [5:0]  lz;
    f = bits & FracMask;
    e = bits[62:52];
    u.sgn = bits[63];
    u.ex = '0;
    u.sig = '0;
    lz = '0;
    if (e == '0) begin
      if (f == '0) begin
        u.kind = K_ZERO;
      end else begin
        u.kind = K_NUM;
        for (int i = 51; i >= 0; i--) begin
          if (f[i] && lz == '0) lz = 6'(52 - i);
        end
        u.ex = ExpW'(-1022) - ExpW'(lz);
        u.sig = (f << 8) << lz;
      end
    end else if (e == ExpAll) begin
      u.kind = (f == '0) ? K_INF : K_NAN;
      u.sig = {12'd0, f[51:0] & (QuietBit - 52'd1)};
    end else begin
      u.kind = K_NUM;
      u.ex = ExpW'({2'b00, e}) - ExpW'(1023);
      u.sig = (f << 8) | (64'd1 << 60);
    end
    return u;
  endfunction

  function automatic logic [63:0] shift_sticky(input logic [63:0] v, input logic [5:0] d);
    logic [63:0] m;
    m = (64'd1 << d) - 64'd1;
    return (v >> d) | {63'd0, (v & m) != '0};
  endfunction

  function automatic logic [63:0] rnd(input logic [63:0] f);
    if (f[7:0] == 8'h80) return f[8] ? f + 64'h80 : f;
    return f + 64'h7f;
  endfunction

  function automatic logic [63:0] pack_num(input logic s, input logic signed [ExpW-1:0] ne,
                                           input logic [63:0] fin);
    logic [63:0] f;
    logic [63:0] e;
    logic signed [ExpW-1:0] sh;
    f = fin;
    e = '0;
    sh = ExpW'(-1022) - ne;
    if (f == '0) return {s, 63'd0};
    if (ne < ExpW'(-1022)) begin
      if (sh > ExpW'(56)) f = '0;
      else f = shift_sticky(f, sh[5:0]);
      f = rnd(f);
      if (f >= (64'd1 << 60)) e = 64'd1;
      f = f >> 8;
    end else if (ne > ExpW'(1023)) begin
      return {s, ExpAll, 52'd0};
    end else begin
      e = 64'(ne + ExpW'(1023));
      f = rnd(f);
      if (f >= (64'd1 << 61)) begin
        f = f >> 1;
        e = e + 64'd1;
      end
      f = f >> 8;
      if (e >= 64'h7ff) return {s, ExpAll, 52'd0};
    end
    return {s, e[10:0], f[51:0]};
  endfunction

  unpacked_t a, b;
  logic signed [ExpW-1:0] d, re;
  logic [63:0] fa, fb, t, mag;
  logic [6:0]  lz;
  logic        rs;

  always_comb begin
    a = split(minuend);
    b = split(subtrahend);
    b.sgn = ~b.sgn;
    fa = a.sig;
    fb = b.sig;
    d = a.ex - b.ex;
    re = a.ex;
    rs = a.sgn;
    t = '0;
    mag = '0;
    lz = '0;
    if (d > 0) begin
      fb = (d < ExpW'(64)) ? shift_sticky(fb, d[5:0]) : '0;
    end else if (d < 0) begin
      fa = (-d < ExpW'(64)) ? shift_sticky(fa, 6'(-d)) : '0;
      re = b.ex;
    end
    if (a.sgn != b.sgn) begin
      t = a.sgn ? fb - fa : fa - fb;
      rs = t[63];
      mag = t[63] ? -t : t;
      // count shifts up to the hidden bit at 60
      for (int i = 60; i >= 0; i--) begin
        if (mag[i] && lz == '0) lz = 7'(61 - i);
      end
      if (mag != '0 && mag < (64'd1 << 60)) begin
        mag = mag << (lz - 7'd1);
        re = re - ExpW'(lz - 7'd1);
      end
    end else begin
      mag = fa + fb;
    end
    if (mag >= (64'd1 << 61)) begin
      mag = shift_sticky(mag, 6'd1);
      re = re + ExpW'(1);
    end

    if (a.kind == K_NAN)
      difference = {a.sgn, ExpAll, QuietBit | a.sig[51:0]};
    else if (b.kind == K_NAN)
      difference = {b.sgn, ExpAll, QuietBit | b.sig[51:0]};
    else if (a.kind == K_INF)
      difference = (b.kind == K_INF && a.sgn != b.sgn) ? CanonNan : {a.sgn, ExpAll, 52'd0};
    else if (b.kind == K_INF)
      difference = {b.sgn, ExpAll, 52'd0};
    else if (b.kind == K_ZERO)
      difference = (a.kind == K_ZERO) ? {a.sgn & b.sgn, 63'd0} : pack_num(a.sgn, a.ex, a.sig);
    else if (a.kind == K_ZERO)
      difference = pack_num(b.sgn, b.ex, b.sig);
    else
      difference = pack_num(rs, re, mag);
  end

endmodule

// ===== src/double_float_subtract_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_float_subtract_core: binary64 a minus b
// Input register, combinational subtract, output register.
// ---------------------------------------------------------------------------
// Takes one request per cycle while the output side takes results; the difference
// passes through the input register and then the result register before it is
// presented. Throughput is one item per cycle, limited only by the output side
// taking results.
module double_float_subtract_core
  import dfs_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  dfs_in_if.sink in_ch,
  dfs_if.source  out_ch
);

  logic        s1_vld_r, s2_vld_r;
  logic [63:0] a_r, b_r, d_r, d_nxt;
  logic        adv1, adv2;

  assign adv2 = ~s2_vld_r | out_ch.ready;
  assign adv1 = ~s1_vld_r | adv2;
  assign in_ch.ready = adv1;

  dfs_datapath u_dp (.minuend(a_r), .subtrahend(b_r), .difference(d_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (adv1) s1_vld_r <= in_ch.valid;
      if (adv2) s2_vld_r <= s1_vld_r;
    end
    if (adv1 && in_ch.valid) begin
      a_r <= in_ch.minuend;
      b_r <= in_ch.subtrahend;
    end
    if (adv2 && s1_vld_r) d_r <= d_nxt;
  end

  assign out_ch.valid = s2_vld_r;
  assign out_ch.data  = d_r;

endmodule
